// ===== rtl/rbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared codes and constants of the rectangle blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package rbe_pkg;

    localparam int PIXEL_BITS   = 8;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_COPY,
        MODE_KEYED,
        MODE_SCALED
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE,
        CFG_SRC_STRIDE,
        CFG_DST_STRIDE,
        CFG_RECT_WIDTH,
        CFG_DST_ROWS,
        CFG_SRC_ROWS,
        CFG_KEY_COLOR,
        CFG_COLOR
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== rtl/rbe_ifs.sv =====
// ----------------------------------------------------------------------------
// rbe request and result channels
// Valid/ready channels carrying blitter requests and blitter results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbe_req_if #(
    parameter int COORD_BITS = 12
);
    import rbe_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [COORD_BITS-1:0] src_x;
    logic [COORD_BITS-1:0] src_y;
    logic [COORD_BITS-1:0] dst_x;
    logic [COORD_BITS-1:0] dst_y;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, kind, src_x, src_y, dst_x, dst_y, pixel, input ready);
    modport sink   (input valid, kind, src_x, src_y, dst_x, dst_y, pixel, output ready);
endinterface

interface rbe_res_if #(
    parameter int ADDR_BITS = 24
);
    import rbe_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  write_enable;
    logic [ADDR_BITS-1:0]  write_address;
    logic [PIXEL_BITS-1:0] write_data;
    logic                  read_valid;
    logic [ADDR_BITS-1:0]  read_address;
    logic                  done_res;

    modport source (output valid, write_enable, write_address, write_data, read_valid,
                    read_address, done_res, input ready);
    modport sink   (input valid, write_enable, write_address, write_data, read_valid,
                    read_address, done_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/rect_blit_engine_unit.sv =====
// ----------------------------------------------------------------------------
// rect_blit_engine_unit
// Rectangle blitter: fill, copy, keyed copy with tint, vertically scaled copy.
// A pixel request's result is registered from S_TICK and waits in S_EMIT while
//   the output stalls; no new request is taken before S_IDLE. A start request
//   makes two passes through the shared multiplier for the corner addresses.
// Scaled mode row turn: S_MUL_NUM, bit-serial divider in S_DIV, S_MUL_ROW.
// Reset: synchronous; config and control registers reset, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_blit_engine_unit #(
    parameter int COORD_BITS = 12,
    parameter int ADDR_BITS  = 24
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    rbe_req_if.sink                                  i_req,
    rbe_res_if.source                                o_res,
    input  wire logic                                i_cfg_we,
    input  wire logic [rbe_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [((COORD_BITS > rbe_pkg::PIXEL_BITS) ? COORD_BITS
                        : rbe_pkg::PIXEL_BITS)-1:0] i_cfg_data
);
    import rbe_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int AW  = ADDR_BITS;
    localparam int PW  = 2 * CW;
    localparam int NW  = PW + 2;
    localparam int EW  = (AW > PW + 1) ? AW : PW + 1;
    localparam int DCW = $clog2(NW + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_DST,
        S_MUL_SRC,
        S_TICK,
        S_MUL_NUM,
        S_DIV,
        S_MUL_ROW,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                  we;
        logic [AW-1:0]         wa;
        logic [PIXEL_BITS-1:0] wd;
        logic                  rv;
        logic [AW-1:0]         ra;
        logic                  dn;
    } t_res;

    t_mode                 r_mode;
    logic [CW-1:0]         r_src_stride;
    logic [CW-1:0]         r_dst_stride;
    logic [CW-1:0]         r_rect_width;
    logic [CW-1:0]         r_dst_rows;
    logic [CW-1:0]         r_src_rows;
    logic [PIXEL_BITS-1:0] r_key;
    logic [PIXEL_BITS-1:0] r_color;

    t_state                r_state;
    logic                  r_busy;
    logic [CW-1:0]         r_col;
    logic [CW-1:0]         r_row;
    logic [AW-1:0]         r_dst_off;
    logic [AW-1:0]         r_src_off;
    logic [AW-1:0]         r_src_org;

    logic [CW-1:0]         r_sx;
    logic [CW-1:0]         r_sy;
    logic [CW-1:0]         r_dx;
    logic [CW-1:0]         r_dy;
    logic [PIXEL_BITS-1:0] r_px;

    logic [NW-1:0]         r_div_num;
    logic [CW:0]           r_div_rem;
    logic [DCW-1:0]        r_div_cnt;

    t_res                  r_res;
    t_res                  r_out;
    logic                  r_out_valid;

    logic [CW-1:0]         w_eff;
    logic [CW-1:0]         h_eff;
    logic [CW-1:0]         mul_a;
    logic [CW-1:0]         mul_b;
    logic [PW-1:0]         mul_p;
    logic [EW-1:0]         mul_addend;
    logic [EW-1:0]         mul_sum;
    logic [CW:0]           col_inc;
    logic [CW:0]           row_inc;
    logic                  col_last;
    logic                  row_last;
    logic                  tk_we;
    logic [PIXEL_BITS-1:0] tk_wd;
    logic                  tk_busy_n;
    logic                  tk_need_div;
    logic [EW-1:0]         dst_step;
    logic [EW-1:0]         src_step;
    logic [AW-1:0]         tk_src_n;
    logic [CW+1:0]         div_sh;
    logic [CW+1:0]         div_den;
    logic                  div_ge;
    logic [CW+1:0]         div_rem_n;
    logic                  fin;
    logic                  out_free;
    logic                  out_load;
    t_res                  n_res;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_FILL;
            r_src_stride <= CW'(1);
            r_dst_stride <= CW'(1);
            r_rect_width <= CW'(1);
            r_dst_rows   <= CW'(1);
            r_src_rows   <= CW'(1);
            r_key        <= '0;
            r_color      <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:       r_mode       <= t_mode'(i_cfg_data[1:0]);
                CFG_SRC_STRIDE: r_src_stride <= i_cfg_data[CW-1:0];
                CFG_DST_STRIDE: r_dst_stride <= i_cfg_data[CW-1:0];
                CFG_RECT_WIDTH: r_rect_width <= i_cfg_data[CW-1:0];
                CFG_DST_ROWS:   r_dst_rows   <= i_cfg_data[CW-1:0];
                CFG_SRC_ROWS:   r_src_rows   <= i_cfg_data[CW-1:0];
                CFG_KEY_COLOR:  r_key        <= i_cfg_data[PIXEL_BITS-1:0];
                CFG_COLOR:      r_color      <= i_cfg_data[PIXEL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_eff = (r_rect_width == '0) ? CW'(1) : r_rect_width;
    assign h_eff = (r_dst_rows == '0) ? CW'(1) : r_dst_rows;

    // shared multiplier
    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        mul_addend = '0;
        case (r_state)
            S_MUL_DST: begin
                mul_a      = r_dy;
                mul_b      = r_dst_stride;
                mul_addend = EW'(r_dx);
            end
            S_MUL_SRC: begin
                mul_a      = r_sy;
                mul_b      = r_src_stride;
                mul_addend = EW'(r_sx);
            end
            S_MUL_NUM: begin
                mul_a = r_row;
                mul_b = r_src_rows;
            end
            S_MUL_ROW: begin
                mul_a      = r_div_num[CW-1:0];
                mul_b      = r_src_stride;
                mul_addend = EW'(r_src_org);
            end
            default: begin
            end
        endcase
    end

    assign mul_p   = PW'(mul_a) * PW'(mul_b);
    assign mul_sum = EW'(mul_p) + mul_addend;

    // pixel step
    assign col_inc  = {1'b0, r_col} + (CW+1)'(1);
    assign row_inc  = {1'b0, r_row} + (CW+1)'(1);
    assign col_last = col_inc >= {1'b0, w_eff};
    assign row_last = row_inc >= {1'b0, h_eff};
    assign dst_step = EW'(r_dst_off) + EW'(1) + EW'(r_dst_stride) - EW'(w_eff);
    assign src_step = EW'(r_src_off) + EW'(1) + EW'(r_src_stride) - EW'(w_eff);
    assign tk_busy_n   = !(col_last && row_last);
    assign tk_need_div = col_last && !row_last && (r_mode == MODE_SCALED);
    assign tk_src_n    = col_last ? src_step[AW-1:0] : r_src_off + AW'(1);

    always_comb begin
        tk_we = 1'b0;
        tk_wd = '0;
        case (r_mode)
            MODE_FILL: begin
                tk_we = 1'b1;
                tk_wd = r_color;
            end
            MODE_COPY: begin
                tk_we = 1'b1;
                tk_wd = r_px;
            end
            MODE_KEYED: begin
                if (!(r_key != '0 && r_px == r_key)) begin
                    tk_we = 1'b1;
                    tk_wd = r_px | r_color;
                end
            end
            default: begin
                if (r_px != r_key) begin
                    tk_we = 1'b1;
                    tk_wd = r_px;
                end
            end
        endcase
    end

    // restoring divider step
    assign div_sh    = {r_div_rem, r_div_num[NW-1]};
    assign div_den   = {1'b0, h_eff, 1'b0};
    assign div_ge    = div_sh >= div_den;
    assign div_rem_n = div_ge ? div_sh - div_den : div_sh;

    // result of the finishing step
    always_comb begin
        fin   = 1'b0;
        n_res = '0;
        case (r_state)
            S_MUL_SRC: begin
                fin      = 1'b1;
                n_res.rv = (r_mode != MODE_FILL);
                n_res.ra = (r_mode != MODE_FILL) ? mul_sum[AW-1:0] : '0;
            end
            S_TICK: begin
                if (r_busy) begin
                    fin      = !tk_need_div;
                    n_res.we = tk_we;
                    n_res.wa = r_dst_off;
                    n_res.wd = tk_wd;
                    n_res.dn = !tk_busy_n;
                    if (tk_busy_n && r_mode != MODE_FILL && !tk_need_div) begin
                        n_res.rv = 1'b1;
                        n_res.ra = tk_src_n;
                    end
                end else begin
                    fin = 1'b1;
                end
            end
            S_MUL_ROW: begin
                fin      = 1'b1;
                n_res    = r_res;
                n_res.rv = 1'b1;
                n_res.ra = mul_sum[AW-1:0];
            end
            default: begin
            end
        endcase
    end

    assign out_free    = !r_out_valid || o_res.ready;
    assign out_load    = out_free && (fin || r_state == S_EMIT);
    assign i_req.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_dst_off   <= '0;
            r_src_off   <= '0;
            r_src_org   <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (fin) begin
                r_res <= n_res;
                if (out_free) begin
                    r_out   <= n_res;
                    r_state <= S_IDLE;
                end else begin
                    r_state <= S_EMIT;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_sx    <= i_req.src_x;
                        r_sy    <= i_req.src_y;
                        r_dx    <= i_req.dst_x;
                        r_dy    <= i_req.dst_y;
                        r_px    <= i_req.pixel;
                        r_state <= i_req.kind ? S_TICK : S_MUL_DST;
                    end
                end
                S_MUL_DST: begin
                    r_dst_off <= mul_sum[AW-1:0];
                    r_state   <= S_MUL_SRC;
                end
                S_MUL_SRC: begin
                    r_src_org <= mul_sum[AW-1:0];
                    r_src_off <= mul_sum[AW-1:0];
                    r_busy    <= 1'b1;
                    r_col     <= '0;
                    r_row     <= '0;
                end
                S_TICK: begin
                    if (r_busy) begin
                        if (col_last) begin
                            r_col <= '0;
                            if (row_last) begin
                                r_busy <= 1'b0;
                                r_row  <= '0;
                            end else begin
                                r_row     <= row_inc[CW-1:0];
                                r_dst_off <= dst_step[AW-1:0];
                                if (!tk_need_div) begin
                                    r_src_off <= src_step[AW-1:0];
                                end
                            end
                        end else begin
                            r_col     <= col_inc[CW-1:0];
                            r_dst_off <= r_dst_off + AW'(1);
                            r_src_off <= r_src_off + AW'(1);
                        end
                        if (tk_need_div) begin
                            r_res   <= n_res;
                            r_state <= S_MUL_NUM;
                        end
                    end
                end
                S_MUL_NUM: begin
                    r_div_num <= {1'b0, mul_p, 1'b0} + NW'(h_eff);
                    r_div_rem <= '0;
                    r_div_cnt <= DCW'(NW);
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_div_num <= {r_div_num[NW-2:0], div_ge};
                    r_div_rem <= div_rem_n[CW:0];
                    r_div_cnt <= r_div_cnt - DCW'(1);
                    if (r_div_cnt == DCW'(1)) begin
                        r_state <= S_MUL_ROW;
                    end
                end
                S_MUL_ROW: begin
                    r_src_off <= mul_sum[AW-1:0];
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.write_enable  = r_out.we;
    assign o_res.write_address = r_out.wa;
    assign o_res.write_data    = r_out.wd;
    assign o_res.read_valid    = r_out.rv;
    assign o_res.read_address  = r_out.ra;
    assign o_res.done_res      = r_out.dn;

    a_done_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.done_res |-> !o_res.read_valid)
        else $error("read requested on last pixel");

    a_skip_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.write_enable |-> o_res.write_data == '0)
        else $error("skipped write carries data");

    a_no_read_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.read_valid |-> o_res.read_address == '0)
        else $error("read address without read request");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rect_blit_engine_unit. A queue-fed driver offers
// start and pixel requests, a monitor checks every result against a cycle-free
// blitter predictor, and both channel sides stall at random between register
// programming phases that cover all four modes and the size extremes.
// ----------------------------------------------------------------------------

module tb_top;
    import rbe_pkg::*;

    localparam int COORD_W   = 12;
    localparam int ADDR_W    = 24;
    localparam int CFG_W     = (COORD_W > PIXEL_BITS) ? COORD_W : PIXEL_BITS;
    localparam int LIMIT     = 600000;
    localparam bit KIND_START = 1'b0;
    localparam bit KIND_TICK  = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [COORD_W-1:0]    src_x;
        logic [COORD_W-1:0]    src_y;
        logic [COORD_W-1:0]    dst_x;
        logic [COORD_W-1:0]    dst_y;
        logic [PIXEL_BITS-1:0] pixel;
    } t_blit_item;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     wa;
        logic [PIXEL_BITS-1:0] wd;
        logic                  rv;
        logic [ADDR_W-1:0]     ra;
        logic                  dn;
    } t_blit_res;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    t_cfg_idx         cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    rbe_req_if #(.COORD_BITS(COORD_W)) req_if ();
    rbe_res_if #(.ADDR_BITS(ADDR_W))   res_if ();

    rect_blit_engine_unit #(
        .COORD_BITS(COORD_W),
        .ADDR_BITS (ADDR_W)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if),
        .o_res     (res_if),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_blit_item   pend_req_q [$];
    t_blit_res    want_res_q [$];
    int           n_pushed   = 0;
    int           n_accepted = 0;
    int           fail_cnt   = 0;
    int           cycle_cnt  = 0;
    bit           req_fire   = 1'b0;
    bit           hold_done  = 1'b0;
    int           hold_left  = 0;
    logic [11:0]  cfg_val [8];

    wire calm_window = (n_accepted >= 200) && (n_accepted < 280);

    // predictor copy of registers and state
    t_mode              p_mode;
    logic [COORD_W-1:0] p_src_stride, p_dst_stride, p_width, p_dst_rows, p_src_rows;
    logic [7:0]         p_key, p_color;
    bit                 p_busy;
    logic [COORD_W-1:0] p_col, p_row;
    logic [ADDR_W-1:0]  p_dst_off, p_src_off, p_src_org;

    function automatic void blit_reset_state();
        p_mode = MODE_FILL;
        p_src_stride = 1; p_dst_stride = 1; p_width = 1;
        p_dst_rows = 1; p_src_rows = 1; p_key = 0; p_color = 0;
        p_busy = 0; p_col = 0; p_row = 0;
        p_dst_off = 0; p_src_off = 0; p_src_org = 0;
    endfunction

    function automatic void apply_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_MODE:       p_mode = t_mode'(data[1:0]);
            CFG_SRC_STRIDE: p_src_stride = data[COORD_W-1:0];
            CFG_DST_STRIDE: p_dst_stride = data[COORD_W-1:0];
            CFG_RECT_WIDTH: p_width = data[COORD_W-1:0];
            CFG_DST_ROWS:   p_dst_rows = data[COORD_W-1:0];
            CFG_SRC_ROWS:   p_src_rows = data[COORD_W-1:0];
            CFG_KEY_COLOR:  p_key = data[7:0];
            CFG_COLOR:      p_color = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic t_blit_res predict_blit(t_blit_item it);
        t_blit_res       r;
        longint unsigned w, h, tmp, srow;
        r = '0;
        w = (p_width == 0) ? 1 : p_width;
        h = (p_dst_rows == 0) ? 1 : p_dst_rows;
        if (it.kind == KIND_START) begin
            p_busy = 1; p_col = 0; p_row = 0;
            tmp = longint'(it.dst_y) * p_dst_stride + it.dst_x;
            p_dst_off = tmp[ADDR_W-1:0];
            tmp = longint'(it.src_y) * p_src_stride + it.src_x;
            p_src_org = tmp[ADDR_W-1:0];
            p_src_off = p_src_org;
            if (p_mode != MODE_FILL) begin
                r.rv = 1; r.ra = p_src_off;
            end
        end else if (p_busy) begin
            r.wa = p_dst_off;
            case (p_mode)
                MODE_FILL: begin
                    r.we = 1; r.wd = p_color;
                end
                MODE_COPY: begin
                    r.we = 1; r.wd = it.pixel;
                end
                MODE_KEYED: begin
                    if (!(p_key != 0 && it.pixel == p_key)) begin
                        r.we = 1; r.wd = it.pixel | p_color;
                    end
                end
                default: begin
                    if (it.pixel != p_key) begin
                        r.we = 1; r.wd = it.pixel;
                    end
                end
            endcase
            if (longint'(p_col) + 1 >= w) begin
                p_col = 0;
                if (longint'(p_row) + 1 >= h) begin
                    p_busy = 0; r.dn = 1; p_row = 0;
                end else begin
                    p_row = p_row + 12'd1;
                    tmp = longint'(p_dst_off) + 1 + p_dst_stride - w;
                    p_dst_off = tmp[ADDR_W-1:0];
                    if (p_mode == MODE_SCALED) begin
                        srow = (2 * longint'(p_row) * p_src_rows + h) / (2 * h);
                        tmp = longint'(p_src_org) + srow * p_src_stride;
                    end else begin
                        tmp = longint'(p_src_off) + 1 + p_src_stride - w;
                    end
                    p_src_off = tmp[ADDR_W-1:0];
                end
            end else begin
                p_col = p_col + 12'd1;
                p_dst_off = p_dst_off + 24'd1;
                p_src_off = p_src_off + 24'd1;
            end
            if (p_busy && p_mode != MODE_FILL) begin
                r.rv = 1; r.ra = p_src_off;
            end
        end
        return r;
    endfunction

    // predictor, monitor and watchdog
    always @(posedge i_clk) begin
        t_blit_item it;
        t_blit_res  got, want;
        if (!i_rst_n) begin
            req_fire <= 1'b0;
            blit_reset_state();
        end else if (cycle_cnt >= LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            cycle_cnt++;
            req_fire <= req_if.valid && req_if.ready;
            if (cfg_we)
                apply_reg(cfg_idx, cfg_data);
            if (req_if.valid && req_if.ready) begin
                it = '{req_if.kind, req_if.src_x, req_if.src_y, req_if.dst_x,
                       req_if.dst_y, req_if.pixel};
                want_res_q.push_back(predict_blit(it));
                n_accepted++;
            end
            if (res_if.valid && res_if.ready) begin
                got = '{res_if.write_enable, res_if.write_address, res_if.write_data,
                        res_if.read_valid, res_if.read_address, res_if.done_res};
                if (want_res_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("tb: unexpected result we=%0b wa=%h wd=%h rv=%0b ra=%h dn=%0b",
                                 got.we, got.wa, got.wd, got.rv, got.ra, got.dn);
                end else begin
                    want = want_res_q.pop_front();
                    if (got.we !== want.we || got.wa !== want.wa || got.wd !== want.wd ||
                        got.rv !== want.rv || got.ra !== want.ra || got.dn !== want.dn) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("tb: mismatch exp we=%0b wa=%h wd=%h rv=%0b ra=%h dn=%0b",
                                     want.we, want.wa, want.wd, want.rv, want.ra, want.dn);
                            $display("tb:          got we=%0b wa=%h wd=%h rv=%0b ra=%h dn=%0b",
                                     got.we, got.wa, got.wd, got.rv, got.ra, got.dn);
                        end
                    end
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_blit_item nxt;
        bit         take;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_fire) begin
            take = (pend_req_q.size() > 0) && (calm_window || $urandom_range(99) >= 19);
            if (take) begin
                nxt = pend_req_q.pop_front();
                req_if.valid <= 1'b1;
                req_if.kind  <= nxt.kind;
                req_if.src_x <= nxt.src_x;
                req_if.src_y <= nxt.src_y;
                req_if.dst_x <= nxt.dst_x;
                req_if.dst_y <= nxt.dst_y;
                req_if.pixel <= nxt.pixel;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // result acceptor with one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (!hold_done && n_accepted >= 100) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= calm_window || ($urandom_range(99) >= 19);
            end
        end
    end

    task automatic push_item(t_blit_item it);
        pend_req_q.push_back(it);
        n_pushed++;
    endtask

    task automatic push_start(logic [11:0] sx, logic [11:0] sy, logic [11:0] dx,
                              logic [11:0] dy);
        push_item('{KIND_START, sx, sy, dx, dy, 8'($urandom)});
    endtask

    task automatic push_tick(logic [7:0] px);
        push_item('{KIND_TICK, 12'($urandom), 12'($urandom), 12'($urandom),
                    12'($urandom), px});
    endtask

    task automatic wait_idle();
        while (!(n_accepted == n_pushed && want_res_q.size() == 0))
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic program_regs(int md, int ss, int ds, int w, int dr, int sr, int key,
                                int col);
        wait_idle();
        cfg_val[CFG_MODE] = 12'(md);
        cfg_val[CFG_SRC_STRIDE] = 12'(ss);
        cfg_val[CFG_DST_STRIDE] = 12'(ds);
        cfg_val[CFG_RECT_WIDTH] = 12'(w);
        cfg_val[CFG_DST_ROWS] = 12'(dr);
        cfg_val[CFG_SRC_ROWS] = 12'(sr);
        cfg_val[CFG_KEY_COLOR] = 12'(key);
        cfg_val[CFG_COLOR] = 12'(col);
        for (int i = 0; i < 8; i++) begin
            @(negedge i_clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= t_cfg_idx'(i);
            cfg_data <= CFG_W'(cfg_val[i]);
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_dim(int small_hi);
        int r;
        r = $urandom_range(99);
        if (r < 65) return $urandom_range(small_hi, 1);
        else if (r < 75) return 0;
        else if (r < 85) return 4095;
        else return $urandom_range(4095);
    endfunction

    function automatic logic [7:0] pick_pixel();
        int r;
        r = $urandom_range(99);
        if (r < 25) return cfg_val[CFG_KEY_COLOR][7:0];
        else if (r < 32) return 8'h00;
        else if (r < 39) return 8'hFF;
        else return 8'($urandom);
    endfunction

    function automatic logic [11:0] pick_coord();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 12'd0;
        else if (r == 1) return 12'hFFF;
        else return 12'($urandom);
    endfunction

    initial begin
        int n_items, full, ticks, w_eff, h_eff;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_MODE;
        cfg_data     = '0;
        req_if.valid = 1'b0;
        req_if.kind  = KIND_TICK;
        req_if.src_x = '0;
        req_if.src_y = '0;
        req_if.dst_x = '0;
        req_if.dst_y = '0;
        req_if.pixel = '0;
        res_if.ready = 1'b0;
        for (int i = 0; i < 8; i++) cfg_val[i] = 12'd0;
        cfg_val[CFG_SRC_STRIDE] = 1; cfg_val[CFG_DST_STRIDE] = 1;
        cfg_val[CFG_RECT_WIDTH] = 1; cfg_val[CFG_DST_ROWS] = 1; cfg_val[CFG_SRC_ROWS] = 1;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: idle tick, fill at both corner extremes
        push_tick(8'hA5);
        push_start(12'd0, 12'd0, 12'd0, 12'd0);
        push_tick(8'hFF);
        push_start(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        push_tick(8'h00);

        // plain copy at maximum strides, addresses wrap within the second row
        program_regs(MODE_COPY, 4095, 4095, 2, 3, 1, 0, 0);
        push_start(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        for (int i = 0; i < 6; i++) push_tick(8'(i * 51));

        // keyed copy with tint
        program_regs(MODE_KEYED, 7, 9, 3, 1, 1, 8'h5A, 8'h81);
        push_start(12'd3, 12'd2, 12'd1, 12'd4);
        push_tick(8'h5A);
        push_tick(8'h00);
        push_tick(8'hFF);

        // key zero disables keying; start while busy abandons the rectangle
        program_regs(MODE_KEYED, 5, 6, 3, 1, 1, 0, 8'h30);
        push_start(12'd1, 12'd1, 12'd1, 12'd1);
        push_tick(8'h00);
        push_start(12'd2, 12'd0, 12'd0, 12'd2);
        push_tick(8'h00);

        // scaled copy, key zero is a real key; first tick continues the rectangle
        program_regs(MODE_SCALED, 4095, 1, 1, 3, 4095, 0, 0);
        push_tick(8'h11);
        push_start(12'd1, 12'd0, 12'd0, 12'd0);
        push_tick(8'h00);
        push_tick(8'h77);
        push_tick(8'h00);

        // zero sizes and zero strides
        program_regs(MODE_SCALED, 0, 0, 0, 0, 0, 8'hFF, 8'hFF);
        push_start(12'd1, 12'd2, 12'd3, 12'd4);
        push_tick(8'hFF);

        for (int ph = 0; ph < 8; ph++) begin
            program_regs($urandom_range(3), pick_dim(64), pick_dim(64), pick_dim(5),
                         pick_dim(4), pick_dim(8),
                         ($urandom_range(3) == 0) ? 0 : $urandom_range(255),
                         $urandom_range(255));
            w_eff = (cfg_val[CFG_RECT_WIDTH] == 0) ? 1 : cfg_val[CFG_RECT_WIDTH];
            h_eff = (cfg_val[CFG_DST_ROWS] == 0) ? 1 : cfg_val[CFG_DST_ROWS];
            full = w_eff * h_eff;
            n_items = 0;
            while (n_items < 34) begin
                push_start(pick_coord(), pick_coord(), pick_coord(), pick_coord());
                if (full <= 24 && $urandom_range(9) < 8)
                    ticks = full;
                else
                    ticks = $urandom_range((full < 24) ? full : 24, 1);
                if ($urandom_range(9) == 0)
                    ticks += $urandom_range(2, 1);
                for (int t = 0; t < ticks; t++) push_tick(pick_pixel());
                n_items += ticks + 1;
            end
        end

        // start of a row at maximum width
        program_regs(MODE_COPY, 4095, 4095, 4095, 1, 1, 0, 0);
        push_start(pick_coord(), pick_coord(), pick_coord(), pick_coord());
        for (int t = 0; t < 40; t++) push_tick(pick_pixel());

        while (!(n_accepted == n_pushed && want_res_q.size() == 0))
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_cnt == 0 && want_res_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
